// ===== src/zsr_pkg.sv =====
package zsr_pkg;

	// Register indexes of the configuration port
	localparam logic [1:0] REG_PEDESTAL  = 2'd0;
	localparam logic [1:0] REG_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_PADDING   = 2'd2;
	localparam int         REG_IDX_W     = 2;

	// Register reset values and widths
	localparam int PEDESTAL_RST  = 100;
	localparam int THRESHOLD_RST = 12;
	localparam int PADDING_RST   = 5;
	localparam int PAD_REG_W     = 5;

	// Distance counter since the last signal sample saturates here
	localparam int              SINCE_W   = 6;
	localparam logic [SINCE_W-1:0] SINCE_MAX = '1;

	// Command from the classifier to the output sequencer
	typedef enum logic [0:0] {
		CMD_STORE = 1'b0,  // non-region sample goes into the preroll line
		CMD_EMIT  = 1'b1   // emit cnt preroll samples, then the sample itself
	} cmd_op_t;

endpackage

// ===== src/zsr_if.sv =====
// Input channel: one ADC sample per transaction
interface zsr_in_if #(
	parameter int SAMPLE_BITS = 12,
	parameter int TICK_BITS   = 16
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample_value;
	logic [TICK_BITS-1:0]   window_start_tick;
	logic                   window_last;

	modport source (output valid, output sample_value, output window_start_tick,
		output window_last, input ready);
	modport sink (input valid, input sample_value, input window_start_tick,
		input window_last, output ready);
endinterface

// Output channel: one kept sample per transaction
interface zsr_out_if #(
	parameter int SAMPLE_BITS = 12,
	parameter int TICK_BITS   = 16
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] kept_sample;
	logic [TICK_BITS-1:0]   roi_start_tick;
	logic                   roi_last;

	modport source (output valid, output kept_sample, output roi_start_tick,
		output roi_last, input ready);
	modport sink (input valid, input kept_sample, input roi_start_tick,
		input roi_last, output ready);
endinterface

// ===== src/zero_suppression_roi_extractor_core.sv =====
// Zero-suppression ROI extractor. Takes the ADC samples of a pad window in
// order and passes on only samples inside regions of interest, each tagged
// with the region's start tick and a last-of-region flag. A classifier
// accepts one sample per cycle and queues a command (four entries) to the
// output sequencer, which owns the preroll line. A sample that only goes
// into the preroll line costs the sequencer a command pop, and a sample
// with a single result a command pop, then an output load. A sample that
// opens a region with preroll occupies the sequencer for a command pop,
// then a registered read of the preroll memory and an output load for
// each preroll sample, then the load of the sample itself. The sequencer
// pops the next command only once it is done with the last. Input stalls
// only when the command queue is full. The output is registered.
// Configuration writes take effect on the next cycle and are meant to be
// made while the block is idle.
module zero_suppression_roi_extractor_core import zsr_pkg::*; #(
	parameter int MAX_PADDING = 31,
	parameter int SAMPLE_BITS = 12,
	parameter int TICK_BITS   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [REG_IDX_W-1:0]   cfg_index,
	input  logic [SAMPLE_BITS-1:0] cfg_data,
	zsr_in_if.sink                 in_ch,
	zsr_out_if.source              out_ch
);

	localparam int CNT_W = $clog2(MAX_PADDING + 1);
	localparam int CMD_W = 1 + CNT_W + SAMPLE_BITS + TICK_BITS + 1;

	logic [SAMPLE_BITS-1:0] pedestal_q;
	logic [SAMPLE_BITS-1:0] threshold_q;
	logic [PAD_REG_W-1:0]   padding_q;

	logic             push, full, pop, head_valid;
	logic [CMD_W-1:0] push_data, head_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pedestal_q  <= SAMPLE_BITS'(PEDESTAL_RST);
			threshold_q <= SAMPLE_BITS'(THRESHOLD_RST);
			padding_q   <= PAD_REG_W'(PADDING_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PEDESTAL:  pedestal_q  <= cfg_data;
				REG_THRESHOLD: threshold_q <= cfg_data;
				REG_PADDING:   padding_q   <= cfg_data[PAD_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	zsr_front #(
		.MAX_PADDING (MAX_PADDING),
		.SAMPLE_BITS (SAMPLE_BITS),
		.TICK_BITS   (TICK_BITS),
		.CNT_W       (CNT_W),
		.CMD_W       (CMD_W)
	) u_front (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.pedestal                (pedestal_q),
		.threshold_over_pedestal (threshold_q),
		.padding                 (padding_q),
		.in_valid                (in_ch.valid),
		.in_ready                (in_ch.ready),
		.sample_value            (in_ch.sample_value),
		.window_start_tick       (in_ch.window_start_tick),
		.window_last             (in_ch.window_last),
		.cmd_push                (push),
		.cmd_data                (push_data),
		.cmd_full                (full)
	);

	zsr_cmd_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (4)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head_data  (head_data),
		.head_valid (head_valid)
	);

	zsr_back #(
		.MAX_PADDING (MAX_PADDING),
		.SAMPLE_BITS (SAMPLE_BITS),
		.TICK_BITS   (TICK_BITS),
		.CNT_W       (CNT_W),
		.CMD_W       (CMD_W)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (head_valid),
		.cmd_data       (head_data),
		.cmd_pop        (pop),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.kept_sample    (out_ch.kept_sample),
		.roi_start_tick (out_ch.roi_start_tick),
		.roi_last       (out_ch.roi_last)
	);

endmodule

// ===== src/zsr_front.sv =====
module zsr_front import zsr_pkg::*; #(
	parameter int MAX_PADDING = 31,
	parameter int SAMPLE_BITS = 12,
	parameter int TICK_BITS   = 16,
	parameter int CNT_W       = $clog2(MAX_PADDING + 1),
	parameter int CMD_W       = 1 + CNT_W + SAMPLE_BITS + TICK_BITS + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic [SAMPLE_BITS-1:0] pedestal,
	input  logic [SAMPLE_BITS-1:0] threshold_over_pedestal,
	input  logic [PAD_REG_W-1:0]   padding,
	// input samples
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sample_value,
	input  logic [TICK_BITS-1:0]   window_start_tick,
	input  logic                   window_last,
	// command queue
	output logic                   cmd_push,
	output logic [CMD_W-1:0]       cmd_data,
	input  logic                   cmd_full
);

	typedef struct packed {
		cmd_op_t                op;
		logic [CNT_W-1:0]       cnt;
		logic [SAMPLE_BITS-1:0] sample;
		logic [TICK_BITS-1:0]   tick;
		logic                   last;
	} cmd_t;

	localparam logic [CNT_W-1:0] PAD_MAX = CNT_W'(MAX_PADDING);

	logic                   wopen_q;
	logic [TICK_BITS-1:0]   base_q;
	logic [TICK_BITS-1:0]   idx_q;
	logic [CNT_W-1:0]       pcnt_q;
	logic                   inreg_q;
	logic [SINCE_W-1:0]     since_q;
	logic [TICK_BITS-1:0]   rstart_q;

	logic                   accept;
	logic [CNT_W-1:0]       pad;
	logic                   sig;
	logic [TICK_BITS-1:0]   base_c, idx_c;
	logic [CNT_W-1:0]       pcnt_c, cnt_c;
	logic                   inreg_c;
	logic [SINCE_W-1:0]     since_c;
	logic                   wopen_n, inreg_n, last_c;
	logic [TICK_BITS-1:0]   idx_n, rstart_n;
	logic [CNT_W-1:0]       pcnt_n;
	logic [SINCE_W-1:0]     since_n;
	cmd_t                   cmd;

	assign accept   = in_valid && in_ready;
	assign in_ready = !cmd_full;
	assign cmd_push = accept;
	assign cmd_data = cmd;

	// effective padding, clipped to MAX_PADDING (one less than the line depth)
	assign pad = ({1'b0, padding} > (PAD_REG_W + 1)'(MAX_PADDING)) ? PAD_MAX : CNT_W'(padding);

	assign sig = {1'b0, sample_value} >= ({1'b0, pedestal} + {1'b0, threshold_over_pedestal});

	// window start resets the per-window state
	always_comb begin
		base_c  = wopen_q ? base_q  : window_start_tick;
		idx_c   = wopen_q ? idx_q   : '0;
		pcnt_c  = wopen_q ? pcnt_q  : '0;
		inreg_c = wopen_q ? inreg_q : 1'b0;
		since_c = wopen_q ? since_q : '0;
	end

	// classify the sample and form its command
	always_comb begin
		cnt_c    = (pcnt_c > pad) ? pad : pcnt_c;
		since_n  = since_c;
		inreg_n  = inreg_c;
		pcnt_n   = pcnt_c;
		rstart_n = rstart_q;
		last_c   = 1'b0;
		cmd.op     = CMD_STORE;
		cmd.cnt    = '0;
		cmd.sample = sample_value;
		cmd.tick   = rstart_q;
		cmd.last   = 1'b0;
		if (inreg_c) begin
			if (sig) begin
				since_n = '0;
			end else if (since_c != SINCE_MAX) begin
				since_n = since_c + 1'b1;
			end
			last_c   = (since_n >= pad) || window_last;
			cmd.op   = CMD_EMIT;
			cmd.last = last_c;
			if (last_c) begin
				inreg_n = 1'b0;
				pcnt_n  = '0;
			end
		end else if (sig) begin
			rstart_n = base_c + idx_c - TICK_BITS'(cnt_c);
			since_n  = '0;
			last_c   = (pad == '0) || window_last;
			inreg_n  = !last_c;
			pcnt_n   = '0;
			cmd.op   = CMD_EMIT;
			cmd.cnt  = cnt_c;
			cmd.tick = rstart_n;
			cmd.last = last_c;
		end else begin
			pcnt_n = (pcnt_c < pad) ? pcnt_c + 1'b1 : pad;
		end
		// window end
		if (window_last) begin
			wopen_n = 1'b0;
			inreg_n = 1'b0;
			pcnt_n  = '0;
			since_n = '0;
			idx_n   = '0;
		end else begin
			wopen_n = 1'b1;
			idx_n   = idx_c + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wopen_q  <= 1'b0;
			base_q   <= '0;
			idx_q    <= '0;
			pcnt_q   <= '0;
			inreg_q  <= 1'b0;
			since_q  <= '0;
			rstart_q <= '0;
		end else if (accept) begin
			wopen_q  <= wopen_n;
			base_q   <= base_c;
			idx_q    <= idx_n;
			pcnt_q   <= pcnt_n;
			inreg_q  <= inreg_n;
			since_q  <= since_n;
			rstart_q <= rstart_n;
		end
	end

endmodule

// ===== src/zsr_cmd_fifo.sv =====
module zsr_cmd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             head_valid
);

	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   count_q;

	assign full       = (count_q == (PTR_W + 1)'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = slot_q[rd_q];

	// storage slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full || pop)
		else $error("command queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("command queue underflow");

endmodule

// ===== src/zsr_back.sv =====
module zsr_back import zsr_pkg::*; #(
	parameter int MAX_PADDING = 31,
	parameter int SAMPLE_BITS = 12,
	parameter int TICK_BITS   = 16,
	parameter int CNT_W       = $clog2(MAX_PADDING + 1),
	parameter int CMD_W       = 1 + CNT_W + SAMPLE_BITS + TICK_BITS + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// command queue head
	input  logic                   cmd_valid,
	input  logic [CMD_W-1:0]       cmd_data,
	output logic                   cmd_pop,
	// result output
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SAMPLE_BITS-1:0] kept_sample,
	output logic [TICK_BITS-1:0]   roi_start_tick,
	output logic                   roi_last
);

	typedef struct packed {
		cmd_op_t                op;
		logic [CNT_W-1:0]       cnt;
		logic [SAMPLE_BITS-1:0] sample;
		logic [TICK_BITS-1:0]   tick;
		logic                   last;
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_LOAD = 4'b0100,
		S_LAST = 4'b1000
	} state_t;

	localparam int LINE_DEPTH = MAX_PADDING + 1;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);
	localparam logic [ADDR_W:0]   DEPTH_V = (ADDR_W + 1)'(LINE_DEPTH);
	localparam logic [ADDR_W-1:0] TOP_A   = ADDR_W'(LINE_DEPTH - 1);

	logic [SAMPLE_BITS-1:0] line_q [LINE_DEPTH];
	logic [SAMPLE_BITS-1:0] rd_data_q;
	logic [ADDR_W-1:0]      wr_q, rd_q;
	logic [CNT_W-1:0]       k_q;
	cmd_t                   cur_q;
	state_t                 state_q;
	logic                   out_valid_q;

	cmd_t                   head;
	logic                   out_free;
	logic                   out_load;
	logic                   store_en;
	logic [ADDR_W-1:0]      start_a;

	assign head      = cmd_data;
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = ((state_q == S_LOAD) || (state_q == S_LAST)) && out_free;
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;
	assign store_en  = cmd_pop && (head.op == CMD_STORE);
	assign out_valid = out_valid_q;

	// oldest preroll entry of the burst, modulo the line depth
	assign start_a = (wr_q >= ADDR_W'(head.cnt)) ? wr_q - ADDR_W'(head.cnt)
		: ADDR_W'({1'b0, wr_q} + DEPTH_V - (ADDR_W + 1)'(head.cnt));

	// preroll line with registered read
	always_ff @(posedge clk) begin
		if (store_en) begin
			line_q[wr_q] <= head.sample;
		end
		if (state_q == S_READ) begin
			rd_data_q <= line_q[rd_q];
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && out_free) begin
			kept_sample    <= rd_data_q;
			roi_start_tick <= cur_q.tick;
			roi_last       <= 1'b0;
		end else if (state_q == S_LAST && out_free) begin
			kept_sample    <= cur_q.sample;
			roi_start_tick <= cur_q.tick;
			roi_last       <= cur_q.last;
		end
	end

	// sequencer: stores preroll samples; on an emit, preroll burst, then the triggering sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			wr_q        <= '0;
			rd_q        <= '0;
			k_q         <= '0;
			cur_q       <= '0;
		end else begin
			// output valid: set on a load, cleared once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (store_en) begin
						wr_q <= (wr_q == TOP_A) ? '0 : wr_q + 1'b1;
					end else if (cmd_pop) begin
						cur_q <= head;
						k_q   <= '0;
						rd_q  <= start_a;
						state_q <= (head.cnt == '0) ? S_LAST : S_READ;
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (out_free) begin
						k_q  <= k_q + 1'b1;
						rd_q <= (rd_q == TOP_A) ? '0 : rd_q + 1'b1;
						state_q <= (k_q + 1'b1 == cur_q.cnt) ? S_LAST : S_READ;
					end
				end
				S_LAST: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_read_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> (state_q == S_LOAD))
		else $error("preroll read not followed by load");
	a_burst_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> (k_q < cur_q.cnt))
		else $error("preroll burst ran past its count");

endmodule
